/* rtl/kdt_pkg.sv */
// ----------------------------------------------------------------------------
// kdt_pkg
// Shared types and constants for the k-smallest distance table.
// ----------------------------------------------------------------------------
package kdt_pkg;

  localparam int unsigned DistW  = 24;
  localparam int unsigned LabelW = 8;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned OutIdxW = 4;

  // 1.0 in unsigned Q8.16.
  localparam logic [DistW-1:0] DIST_ONE = 24'h01_0000;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_e;

  typedef enum logic [StatW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_RANGE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Operation presented to every cell while a scan runs.
  typedef struct packed {
    action_e           action;
    logic [SlotW-1:0]  slot;
  } op_t;

  // Write broadcast to the cells at the end of an accepted insert.
  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  idx;
    logic [DistW-1:0]  distance;
    logic [LabelW-1:0] label;
  } wr_t;

  // Scan result handed from cell to cell.
  typedef struct packed {
    logic              have;
    logic              free;
    logic [SlotW-1:0]  idx;
    logic [DistW-1:0]  distance;
    logic [LabelW-1:0] label;
    logic              used;
  } carry_t;

  localparam carry_t CARRY_INIT = '{
    have:     1'b0,
    free:     1'b0,
    idx:      '0,
    distance: '0,
    label:    '0,
    used:     1'b0
  };

endpackage

/* rtl/kdt_cell.sv */
// ----------------------------------------------------------------------------
// kdt_cell
// One table slot: holds an entry and passes the running scan result on.
// ----------------------------------------------------------------------------
module kdt_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kdt_pkg::op_t    op_i,
  input  kdt_pkg::wr_t    wr_i,
  input  kdt_pkg::carry_t carry_i,
  output kdt_pkg::carry_t carry_o
);

  localparam logic [kdt_pkg::SlotW-1:0] MyIdx = kdt_pkg::SlotW'(CellIdx);

  logic [kdt_pkg::DistW-1:0]  dist_q;
  logic [kdt_pkg::LabelW-1:0] label_q;
  logic                       used_q;
  kdt_pkg::carry_t            carry_d, carry_q;
  logic                       take;

  always_comb begin
    take = 1'b0;
    carry_d = carry_i;
    if (op_i.action == kdt_pkg::ACT_READ) begin
      take = (op_i.slot == MyIdx);
    end else if (!carry_i.free) begin
      // The first unused slot wins outright; otherwise keep the first maximum.
      if (!used_q) begin
        take = 1'b1;
        carry_d.free = 1'b1;
      end else if (!carry_i.have || (dist_q > carry_i.distance)) begin
        take = 1'b1;
      end
    end
    if (take) begin
      carry_d.have     = 1'b1;
      carry_d.idx      = MyIdx;
      carry_d.distance = dist_q;
      carry_d.label    = label_q;
      carry_d.used     = used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q  <= kdt_pkg::DIST_ONE;
      label_q <= '0;
      used_q  <= 1'b0;
    end else if (wr_i.en && (wr_i.idx == MyIdx)) begin
      dist_q  <= wr_i.distance;
      label_q <= wr_i.label;
      used_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= kdt_pkg::CARRY_INIT;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;

endmodule

/* rtl/k_smallest_distance_table.sv */
// The scan result moves one cell per cycle down the chain of slots; in the
// DONE state the table is then updated and the result loaded, as soon as the
// output register is free. A new item is accepted only in the idle state,
// after the previous result has been loaded; a result that is not taken holds
// the block in DONE. Reset is asynchronous, active low; all slots become unused
// with distance 1.0 at once.
// ----------------------------------------------------------------------------
// k_smallest_distance_table
// Keeps the smallest candidate distances seen, with labels, in a cell chain.
// ----------------------------------------------------------------------------
module k_smallest_distance_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [kdt_pkg::DistW-1:0]     distance_i,
  input  logic [kdt_pkg::LabelW-1:0]    label_i,
  input  logic [kdt_pkg::SlotW-1:0]     slot_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kdt_pkg::StatW-1:0]     status_o,
  output logic [kdt_pkg::OutIdxW-1:0]   slot_index_o,
  output logic [kdt_pkg::LabelW-1:0]    slot_label_o,
  output logic [kdt_pkg::DistW-1:0]     slot_distance_o,
  output logic                          slot_used_o
);

  localparam int unsigned CntW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(TABLE_ENTRIES - 1);
  localparam logic [kdt_pkg::SlotW:0] NumSlots = (kdt_pkg::SlotW + 1)'(TABLE_ENTRIES);

  kdt_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  kdt_pkg::op_t               op_q;
  logic [kdt_pkg::DistW-1:0]  dist_q;
  logic [kdt_pkg::LabelW-1:0] label_q;

  kdt_pkg::wr_t    wr;
  kdt_pkg::carry_t carry_w [TABLE_ENTRIES];
  kdt_pkg::carry_t res;

  logic in_xfer, load_out, scan_end, ins_accept, out_of_range;

  logic                        out_valid_q, out_valid_d;
  kdt_pkg::status_e            status_q, status_d;
  logic [kdt_pkg::OutIdxW-1:0] idx_q, idx_d;
  logic [kdt_pkg::LabelW-1:0]  olabel_q, olabel_d;
  logic [kdt_pkg::DistW-1:0]   odist_q, odist_d;
  logic                        oused_q, oused_d;

  // Chain of slot cells.
  for (genvar j = 0; j < TABLE_ENTRIES; j++) begin : g_cell
    kdt_pkg::carry_t cin;
    if (j == 0) begin : g_head
      assign cin = kdt_pkg::CARRY_INIT;
    end else begin : g_link
      assign cin = carry_w[j-1];
    end
    kdt_cell #(
      .CellIdx(j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op_q),
      .wr_i   (wr),
      .carry_i(cin),
      .carry_o(carry_w[j])
    );
  end

  assign res          = carry_w[TABLE_ENTRIES-1];
  assign in_xfer      = in_valid_i && in_ready_o;
  assign scan_end     = (cnt_q == CntLast);
  assign ins_accept   = !res.used || (dist_q < res.distance);
  assign out_of_range = ({1'b0, op_q.slot} >= NumSlots);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      kdt_pkg::ST_IDLE: if (in_valid_i) state_d = kdt_pkg::ST_SCAN;
      kdt_pkg::ST_SCAN: if (scan_end) state_d = kdt_pkg::ST_DONE;
      kdt_pkg::ST_DONE: if (!out_valid_q || out_ready_i) state_d = kdt_pkg::ST_IDLE;
      default:          state_d = kdt_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    cnt_d      = cnt_q;
    case (state_q)
      kdt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
      end
      kdt_pkg::ST_SCAN: cnt_d = cnt_q + CntW'(1);
      kdt_pkg::ST_DONE: load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    wr.en       = load_out && (op_q.action == kdt_pkg::ACT_INSERT) && ins_accept;
    wr.idx      = res.idx;
    wr.distance = dist_q;
    wr.label    = label_q;
  end

  // Result selection.
  always_comb begin
    status_d = kdt_pkg::STATUS_OK;
    idx_d    = res.idx[kdt_pkg::OutIdxW-1:0];
    olabel_d = res.label;
    odist_d  = res.distance;
    oused_d  = res.used;
    if (op_q.action == kdt_pkg::ACT_INSERT) begin
      if (ins_accept) begin
        olabel_d = label_q;
        odist_d  = dist_q;
        oused_d  = 1'b1;
      end else begin
        status_d = kdt_pkg::STATUS_REJECT;
      end
    end else if (out_of_range) begin
      status_d = kdt_pkg::STATUS_RANGE;
      idx_d    = '0;
      olabel_d = '0;
      odist_d  = '0;
      oused_d  = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kdt_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q.action <= kdt_pkg::action_e'(action_i);
      op_q.slot   <= slot_i;
      dist_q      <= distance_i;
      label_q     <= label_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= status_d;
      idx_q    <= idx_d;
      olabel_q <= olabel_d;
      odist_q  <= odist_d;
      oused_q  <= oused_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_index_o    = idx_q;
  assign slot_label_o    = olabel_q;
  assign slot_distance_o = odist_q;
  assign slot_used_o     = oused_q;

endmodule

/* rtl/kdt_checker.sv */
// ----------------------------------------------------------------------------
// kdt_checker
// Port-level checks for the k-smallest distance table.
// ----------------------------------------------------------------------------
module kdt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [kdt_pkg::StatW-1:0]   status_o,
  input logic [kdt_pkg::OutIdxW-1:0] slot_index_o,
  input logic [kdt_pkg::LabelW-1:0]  slot_label_o,
  input logic [kdt_pkg::DistW-1:0]   slot_distance_o,
  input logic                        slot_used_o
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(slot_index_o) && $stable(slot_distance_o) && $stable(slot_label_o))
    else $error("result changed while stalled");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == kdt_pkg::STATUS_OK) ||
    (status_o == kdt_pkg::STATUS_REJECT) || (status_o == kdt_pkg::STATUS_RANGE))
    else $error("undefined status code");

  // An out-of-range read reports all data fields as zero.
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == kdt_pkg::STATUS_RANGE) |->
    (slot_index_o == '0) && (slot_label_o == '0) && (slot_distance_o == '0) &&
    !slot_used_o)
    else $error("out-of-range read returned data");

  // A rejection only happens against a used slot.
  a_reject_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == kdt_pkg::STATUS_REJECT) |-> slot_used_o)
    else $error("insert rejected against an unused slot");

  // The block is busy for the scan after each input transfer.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken during a scan");

endmodule

bind k_smallest_distance_table kdt_checker u_kdt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .slot_index_o   (slot_index_o),
  .slot_label_o   (slot_label_o),
  .slot_distance_o(slot_distance_o),
  .slot_used_o    (slot_used_o)
);
